FILE: rtl/hbs_pkg.sv
package hbs_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned AddrBits = 16;
  localparam int unsigned CoordBits = 24;
  localparam int unsigned HeightBits = 16;
  localparam int unsigned CountBits = 9;
  localparam int unsigned Entries = 1 << AddrBits;
  // span needs 25 bits; 2c+span needs 26 signed bits
  localparam int unsigned SpanBits = CoordBits + 1;
  localparam int unsigned NumBits = CoordBits + 2;
  // product num*(n-1)*2^F: 25 + 8 + 8 = 41 bits unsigned
  localparam int unsigned ProdBits = SpanBits + 8 + FracBits;
  // t is at most (n-1)<<F: 16 bits
  localparam int unsigned TBits = 8 + FracBits;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    REG_X_LOW   = 3'd0,
    REG_X_HIGH  = 3'd1,
    REG_Z_LOW   = 3'd2,
    REG_Z_HIGH  = 3'd3,
    REG_COLUMNS = 3'd4,
    REG_ROWS    = 3'd5
  } reg_index_t;

  // Query prepared by the front end: clamped numerators and spans per axis
  typedef struct packed {
    logic                zero_span;
    logic [SpanBits-1:0] num_x;     // 2c+span, saturated at zero
    logic [SpanBits-1:0] span_x;
    logic [SpanBits-1:0] num_z;
    logic [SpanBits-1:0] span_z;
    logic [7:0]          nm1_x;     // point count minus one
    logic [7:0]          nm1_z;
    logic [CountBits-1:0] rows;
  } query_t;

  function automatic logic [SpanBits-1:0] mag24(input logic signed [CoordBits-1:0] v);
    logic signed [SpanBits-1:0] e;
    e = SpanBits'(v);
    return (e < 0) ? SpanBits'(-e) : SpanBits'(e);
  endfunction

endpackage

FILE: rtl/hbs_if.sv
interface hbs_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] entry_index;
  logic signed [15:0] entry_height;
  logic signed [23:0] query_x;
  logic signed [23:0] query_z;
  modport source (output valid, action, entry_index, entry_height, query_x, query_z,
                  input ready);
  modport sink (input valid, action, entry_index, entry_height, query_x, query_z,
                output ready);
endinterface

interface hbs_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic signed [15:0] height;
  modport source (output valid, height, input ready);
  modport sink (input valid, height, output ready);
endinterface

FILE: rtl/hbs_ram.sv
module hbs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/hbs_front.sv
// Front end: clamps the query coordinates and forms numerators and spans.
module hbs_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic signed [23:0]       in_x,
  input  logic signed [23:0]       in_z,
  input  logic signed [23:0]       x_low,
  input  logic signed [23:0]       x_high,
  input  logic signed [23:0]       z_low,
  input  logic signed [23:0]       z_high,
  input  logic [8:0]               grid_columns,
  input  logic [8:0]               grid_rows,
  input  logic                     hold_load,
  output logic                     q_valid,
  input  logic                     q_ready,
  output hbs_pkg::query_t          q_data
);
  localparam int unsigned SB = hbs_pkg::SpanBits;
  localparam int unsigned NB = hbs_pkg::NumBits;

  logic [SB-1:0] span_x, span_z;
  logic signed [23:0] cx, cz;
  logic signed [NB-1:0] nx, nz;
  hbs_pkg::query_t qn;
  logic room;

  assign span_x = hbs_pkg::mag24(x_high) + hbs_pkg::mag24(x_low);
  assign span_z = hbs_pkg::mag24(z_high) + hbs_pkg::mag24(z_low);

  // clamp: raise to low first, else lower to high
  always_comb begin
    priority if (in_x < x_low) cx = x_low;
    else if (in_x > x_high)    cx = x_high;
    else                       cx = in_x;
    priority if (in_z < z_low) cz = z_low;
    else if (in_z > z_high)    cz = z_high;
    else                       cz = in_z;
    nx = (NB'(cx) <<< 1) + $signed({1'b0, span_x});
    nz = (NB'(cz) <<< 1) + $signed({1'b0, span_z});
    qn.zero_span = (span_x == '0) || (span_z == '0);
    qn.num_x  = (nx <= 0) ? '0 : nx[SB-1:0];
    qn.num_z  = (nz <= 0) ? '0 : nz[SB-1:0];
    qn.span_x = span_x;
    qn.span_z = span_z;
    qn.nm1_x  = (grid_columns == '0) ? 8'd0 : 8'(grid_columns - 9'd1);
    qn.nm1_z  = (grid_rows == '0) ? 8'd0 : 8'(grid_rows - 9'd1);
    qn.rows   = (grid_rows == '0) ? 9'd1 : grid_rows;
  end

  // one-entry output register; loads are not forwarded and wait while
  // an earlier query is still in flight anywhere up to its result
  assign room = !q_valid || q_ready;
  assign in_ready = room && !(hold_load && (in_action == hbs_pkg::ACT_LOAD));

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (room) begin
      q_valid <= in_valid && in_ready && (in_action == hbs_pkg::ACT_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_data <= qn;
    end
  end
endmodule

FILE: rtl/hbs_fifo.sv
// Two-entry queue between front and back end.
module hbs_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hbs_pkg::query_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output hbs_pkg::query_t out_data
);
  hbs_pkg::query_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = mem[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
  end
endmodule

FILE: rtl/hbs_back.sv
// Back end: bit-serial divide per axis, four reads, three blends.
module hbs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  hbs_pkg::query_t q_data,
  output logic [15:0]     raddr,
  input  logic [15:0]     rdata,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_height
);
  localparam int unsigned SB = hbs_pkg::SpanBits;
  localparam int unsigned PB = hbs_pkg::ProdBits;
  localparam int unsigned TB = hbs_pkg::TBits;
  localparam int unsigned FB = hbs_pkg::FracBits;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_ADDR = 7'b0001000,
    S_READ = 7'b0010000,
    S_MIX  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  hbs_pkg::query_t q;
  logic [PB-1:0] pnx, pnz;      // numerators, then quotient bits shift in
  logic [SB+7:0] mx, mz;        // numerator times point count minus one
  logic [SB+1:0] remx, remz;    // partial remainders
  logic [5:0]    step;
  logic [TB-1:0] tx, tz;
  logic [7:0]    xi, xn, zi, zn;
  logic [1:0]    rsel;
  logic [2:0]    rcnt;
  logic signed [15:0] h [4];
  logic signed [15:0] i1, i2;
  logic [1:0]    mix;
  logic [FB-1:0] ax, axn;

  // restoring divide step against 2*span
  function automatic logic [SB+1:0] dstep(input logic [SB+1:0] r, input logic b,
                                          input logic [SB-1:0] s, output logic qb);
    logic [SB+1:0] t;
    logic [SB+1:0] d;
    t = {r[SB:0], b};
    d = {1'b0, s, 1'b0};
    qb = (t >= d);
    return qb ? t - d : t;
  endfunction

  function automatic logic signed [15:0] blend(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic [FB-1:0] f);
    logic signed [17+FB:0] p;
    p = $signed({1'b0, f}) * (18'(b) - 18'(a));
    return 16'(18'(a) + 18'(p >>> FB));
  endfunction

  function automatic logic [TB-1:0] sat_t(input logic [PB-1:0] qv, input logic [7:0] nm1);
    logic [TB-1:0] tmax;
    tmax = {nm1, {FB{1'b0}}};
    return (qv > PB'(tmax)) ? tmax : qv[TB-1:0];
  endfunction

  assign q_ready = (state == S_IDLE);

  // 25 x 8 bit products
  assign mx = q.num_x * q.nm1_x;
  assign mz = q.num_z * q.nm1_z;

  // mapped value per axis, saturated at the grid edge
  always_comb begin
    if (q.zero_span) begin
      tx = '0;
      tz = '0;
    end else begin
      tx = sat_t(pnx, q.nm1_x);
      tz = sat_t(pnz, q.nm1_z);
    end
  end

  always_comb begin
    unique case (rsel)
      2'd0: raddr = 16'({8'd0, xi} * q.rows) + 16'(zi);
      2'd1: raddr = 16'({8'd0, xn} * q.rows) + 16'(zi);
      2'd2: raddr = 16'({8'd0, xi} * q.rows) + 16'(zn);
      default: raddr = 16'({8'd0, xn} * q.rows) + 16'(zn);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          q <= q_data;
          state <= S_MUL;
        end
        S_MUL: begin
          pnx <= {mx, {FB{1'b0}}};
          pnz <= {mz, {FB{1'b0}}};
          remx <= '0;
          remz <= '0;
          step <= '0;
          state <= q.zero_span ? S_ADDR : S_DIV;
        end
        S_DIV: begin
          logic bx, bz;
          remx <= dstep(remx, pnx[PB-1], q.span_x, bx);
          remz <= dstep(remz, pnz[PB-1], q.span_z, bz);
          pnx <= {pnx[PB-2:0], bx};
          pnz <= {pnz[PB-2:0], bz};
          step <= step + 6'd1;
          if (step == 6'(PB - 1)) state <= S_ADDR;
        end
        S_ADDR: begin
          // zero span reads entry 0 for all four corners
          xi <= tx[TB-1:FB];
          zi <= tz[TB-1:FB];
          xn <= q.zero_span ? 8'd0 :
                (tx[TB-1:FB] >= q.nm1_x) ? q.nm1_x : tx[TB-1:FB] + 8'd1;
          zn <= q.zero_span ? 8'd0 :
                (tz[TB-1:FB] >= q.nm1_z) ? q.nm1_z : tz[TB-1:FB] + 8'd1;
          ax <= tx[FB-1:0];
          axn <= tz[FB-1:0];
          rsel <= 2'd0;
          rcnt <= 3'd0;
          state <= S_READ;
        end
        S_READ: begin
          // one read issued per cycle, its data registered by the store and captured in the next
          if (rcnt != 3'd0) h[2'(rcnt - 3'd1)] <= $signed(rdata);
          rsel <= rsel + 2'd1;
          rcnt <= rcnt + 3'd1;
          if (rcnt == 3'd4) begin
            mix <= 2'd0;
            state <= S_MIX;
          end
        end
        S_MIX: begin
          mix <= mix + 2'd1;
          if (mix == 2'd0) begin
            i1 <= blend(h[0], h[1], ax);
            i2 <= blend(h[2], h[3], ax);
          end else begin
            out_height <= blend(i1, i2, axn);
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/heightmap_bilinear_sampler.sv
// Bilinear height sampler over a 64K-entry grid (column-major, x outer).
// Loads write the grid store directly, one per cycle, but a load waits while
// any query is still in the front register, the queue or the back end, so a
// query always reads the grid as it stood when the query was accepted. A
// query is registered by the front end into a two-entry queue; the back end
// then holds it through capture, a multiply, a 41-step bit-serial divide per
// axis (skipped when a span is zero), an index step, four reads through the
// store's one read port, the blends and a result state held until the result
// is taken. The back end takes no new query until its result is taken.
// Reading an unwritten entry is undefined.
module heightmap_bilinear_sampler (
  input  logic          clk,
  input  logic          rst,
  hbs_in_if.sink        in_ch,
  hbs_out_if.source     out_ch,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_data
);
  logic signed [23:0] x_low, x_high, z_low, z_high;
  logic [8:0] grid_columns, grid_rows;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low <= 24'sd0;
      x_high <= 24'sd256;
      z_low <= 24'sd0;
      z_high <= 24'sd256;
      grid_columns <= 9'd256;
      grid_rows <= 9'd256;
    end else if (cfg_we) begin
      unique case (hbs_pkg::reg_index_t'(cfg_index))
        hbs_pkg::REG_X_LOW:   x_low <= cfg_data;
        hbs_pkg::REG_X_HIGH:  x_high <= cfg_data;
        hbs_pkg::REG_Z_LOW:   z_low <= cfg_data;
        hbs_pkg::REG_Z_HIGH:  z_high <= cfg_data;
        hbs_pkg::REG_COLUMNS: grid_columns <= cfg_data[8:0];
        hbs_pkg::REG_ROWS:    grid_rows <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic fq_valid, fq_ready, bq_valid, bq_ready;
  hbs_pkg::query_t fq_data, bq_data;
  logic [15:0] raddr, rdata;
  logic load_we;
  logic q_busy;

  // a query is in flight anywhere between front register and result
  assign q_busy = fq_valid || bq_valid || !bq_ready;

  hbs_front u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.action),
    .in_x(in_ch.query_x), .in_z(in_ch.query_z),
    .x_low, .x_high, .z_low, .z_high, .grid_columns, .grid_rows,
    .hold_load(q_busy),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  hbs_fifo u_fifo (
    .clk, .rst,
    .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
    .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data)
  );

  hbs_back u_back (
    .clk, .rst,
    .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .raddr, .rdata,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_height(out_ch.height)
  );

  // loads write on acceptance; they are only accepted with no query in flight
  assign load_we = in_ch.valid && in_ch.ready && (in_ch.action == hbs_pkg::ACT_LOAD);

  hbs_ram #(.Width(16), .Depth(hbs_pkg::Entries)) u_store (
    .clk, .we(load_we), .waddr(in_ch.entry_index), .wdata(in_ch.entry_height),
    .raddr, .rdata
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.height))
    else $error("result changed while stalled");
  a_no_load_fwd: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && in_ch.action == hbs_pkg::ACT_LOAD
      |=> !u_front.q_valid)
    else $error("load forwarded to back end");
  a_fifo_flow: assert property (@(posedge clk) disable iff (rst)
    fq_valid && !fq_ready |=> fq_valid)
    else $error("queued query dropped");
endmodule
